@@ sv/mie_pkg.sv @@
package mie_pkg;

  localparam int ValueW   = 64;
  localparam int ModulusW = 63;
  localparam int ShiftW   = 6;

  // one inversion request
  typedef struct packed {
    logic [ValueW-1:0]   value;
    logic [ModulusW-1:0] modulus;
  } mie_req_t;

  // one inversion result
  typedef struct packed {
    logic [ValueW-1:0] inverse;
    logic              has_inverse;
  } mie_rsp_t;

  // engine status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } mie_status_t;

  // euclid sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_DONE
  } mie_state_t;

endpackage

@@ sv/mie_engine.sv @@
module mie_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mie_pkg::mie_req_t   req,
  input  logic                ack,
  output mie_pkg::mie_status_t status,
  output mie_pkg::mie_rsp_t   result
);
  import mie_pkg::*;

  mie_state_t state, state_next;

  // remainder pair, coefficient pair, aligned divisor and its shift
  logic [ValueW-1:0]   r0, r1, c0, c1, d;
  logic [ShiftW-1:0]   k;
  logic [ModulusW-1:0] m;
  logic                zero_v;

  logic [ValueW-1:0]   cs, rdiff, cdiff;
  logic                ge, fits;

  // shared compare / subtract unit
  assign cs    = c1 << k;
  assign ge    = r0 >= d;
  assign rdiff = r0 - d;
  assign cdiff = c0 - cs;
  assign fits  = {d, 1'b0} <= {1'b0, r0};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_CHECK;
      ST_CHECK: begin
        if (zero_v || r1 == '0) state_next = ST_DONE;
        else state_next = ST_ALIGN;
      end
      ST_ALIGN: if (!fits) state_next = ST_SUB;
      ST_SUB:   if (k == '0) state_next = ST_CHECK;
      ST_DONE:  if (ack) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          r0     <= req.value;
          r1     <= {1'b0, req.modulus};
          c0     <= ValueW'(1);
          c1     <= '0;
          m      <= req.modulus;
          zero_v <= (req.value == '0);
        end
      end
      ST_CHECK: begin
        d <= r1;
        k <= '0;
      end
      ST_ALIGN: begin
        if (fits) begin
          d <= {d[ValueW-2:0], 1'b0};
          k <= k + ShiftW'(1);
        end
      end
      ST_SUB: begin
        if (k == '0) begin
          // last quotient bit: rotate the pairs
          r0 <= r1;
          c0 <= c1;
          r1 <= ge ? rdiff : r0;
          c1 <= ge ? cdiff : c0;
        end else begin
          if (ge) begin
            r0 <= rdiff;
            c0 <= cdiff;
          end
          d <= {1'b0, d[ValueW-1:1]};
          k <= k - ShiftW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // status and result
  always_comb begin
    status.idle        = (state == ST_IDLE);
    status.done        = (state == ST_DONE);
    result.has_inverse = !zero_v && (r0 == ValueW'(1));
    if (!result.has_inverse) result.inverse = '0;
    else if (c0[ValueW-1])   result.inverse = c0 + {1'b0, m};
    else                     result.inverse = c0;
  end

endmodule

@@ sv/modular_inverse_ext_euclid.sv @@
// modular inverse by the extended euclidean algorithm
// request channel: req carries value and modulus, taken when req_valid is
// high and req_stall is low. result channel: rsp carries inverse and
// has_inverse, taken when rsp_valid is high and rsp_stall is low.
// one result per request. a zero value, or a gcd other than one, gives
// inverse 0 with has_inverse clear.
// each euclid step runs in the shared compare/subtract unit: a check,
// a divisor alignment pass and a quotient-bit subtract pass. around the
// steps come load, finish and output. the engine takes one request at a
// time and holds req_stall high while it works.
// the output register lets the engine take the next request while a
// result waits; if the receiver stalls, the finished engine holds its
// result until the output register frees.
// reset (rst, synchronous) empties the output register and idles the engine.
module modular_inverse_ext_euclid (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  mie_pkg::mie_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output mie_pkg::mie_rsp_t rsp
);
  import mie_pkg::*;

  mie_status_t status;
  mie_rsp_t    result;
  logic        start, ack;

  assign req_stall = !status.idle;
  assign start     = req_valid && status.idle;
  assign ack       = status.done && (!rsp_valid || !rsp_stall);

  // iterative euclid engine
  mie_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .ack    (ack),
    .status (status),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ack) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      rsp <= result;
    end
  end

endmodule

@@ sv/mie_checker.sv @@
module mie_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input mie_pkg::mie_rsp_t rsp
);
  import mie_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a taken request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while not busy");

  // no inverse means a zero inverse
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.has_inverse |-> rsp.inverse == '0)
    else $error("nonzero inverse without has_inverse");

  // a lifted inverse never reaches the top bit
  a_inv_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_inverse |-> !rsp.inverse[ValueW-1])
    else $error("inverse out of range");

endmodule

bind modular_inverse_ext_euclid mie_checker u_mie_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mie_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 600;
  localparam int HoldCycles  = 3000;

  // expected inverses, checked in request order
  class inverse_scoreboard;
    mie_rsp_t pending_q[$];
    int unsigned errors = 0;

    // extended euclid tracking only the value's coefficient, 64-bit wrap
    function mie_rsp_t predict(mie_req_t r);
      logic [63:0] m, a, b, q, rem, c0, c1, cn;
      mie_rsp_t res;
      m   = {1'b0, r.modulus};
      res = '0;
      if (r.value == 64'd0) return res;
      a  = r.value;
      b  = m;
      c0 = 64'd1;
      c1 = 64'd0;
      while (b != 64'd0) begin
        q   = a / b;
        rem = a % b;
        cn  = c0 - q * c1;
        a   = b;
        b   = rem;
        c0  = c1;
        c1  = cn;
      end
      if (a != 64'd1) return res;
      // lift a negative coefficient into range
      if (c0[63]) c0 = c0 + m;
      res.inverse     = c0;
      res.has_inverse = 1'b1;
      return res;
    endfunction

    function void note_request(mie_req_t r);
      pending_q.push_back(predict(r));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(mie_rsp_t got);
      mie_rsp_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with nothing pending: inverse=%h has_inverse=%b",
                         got.inverse, got.has_inverse));
        return;
      end
      want = pending_q.pop_front();
      if (got.inverse !== want.inverse)
        report($sformatf("inverse %h, expected %h", got.inverse, want.inverse));
      if (got.has_inverse !== want.has_inverse)
        report($sformatf("has_inverse %b, expected %b", got.has_inverse,
                         want.has_inverse));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  mie_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  mie_rsp_t rsp;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_results = 1'b0;
  int  cycle_count = 0;

  inverse_scoreboard inverse_sb = new();

  modular_inverse_ext_euclid i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** modular_inverse_ext_euclid: FAILED **");
      $finish;
    end
  end

  // result side stall, random or held off
  always @(negedge clk) begin
    rsp_stall <= hold_results || ($urandom_range(0, 99) < stall_pct);
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid === 1'b1 && req_stall === 1'b0) inverse_sb.note_request(req);
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) inverse_sb.check_result(rsp);
    end
  end

  function automatic mie_req_t request_of(logic [63:0] v, logic [62:0] m);
    mie_req_t r;
    r.value   = v;
    r.modulus = m;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random request mix: zero, wide, reduced, small, shared factor, prime modulus, shifted
  function automatic mie_req_t random_request();
    mie_req_t r;
    logic [63:0] v;
    logic [63:0] m;
    int f;
    v = rand64();
    m = rand64();
    case ($urandom_range(0, 19))
      0: begin
        v = 64'd0;
      end
      1, 2, 3, 4, 5, 6: ;
      7, 8, 9: begin
        if (m[62:0] != 63'd0) v = v % {1'b0, m[62:0]};
      end
      10, 11: begin
        m = 64'($urandom_range(0, 16));
        if ($urandom_range(0, 1) == 1) v = 64'($urandom_range(0, 40));
      end
      12, 13: begin
        // common factor, so no inverse
        f = $urandom_range(2, 50);
        m = {8'd0, m[55:0]} * 64'(f);
        v = {6'd0, v[57:0]} * 64'(f);
      end
      14, 15, 16: begin
        m = 64'h1FFF_FFFF_FFFF_FFFF;
      end
      default: begin
        v = v >> $urandom_range(0, 63);
        m = m >> $urandom_range(1, 63);
      end
    endcase
    r.value   = v;
    r.modulus = m[62:0];
    return r;
  endfunction

  // offer one request, with random gaps, and wait until it is taken
  task send_request(mie_req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task send_random(int n);
    repeat (n) send_request(random_request());
  endtask

  task run_phase(int n, int idle_pct, int stall_p);
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    send_random(n);
  endtask

  // receiver holds off for a counted stretch
  task hold_off(int cycles);
    hold_results = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_results = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed corners, no idling
    send_request(request_of(64'd0, 63'd7));
    send_request(request_of(64'd0, 63'd0));
    send_request(request_of(64'd1, 63'd0));
    send_request(request_of(64'd5, 63'd0));
    send_request(request_of(64'hFFFF_FFFF_FFFF_FFFF, 63'd0));
    send_request(request_of(64'd9, 63'd1));
    send_request(request_of(64'hFFFF_FFFF_FFFF_FFFF, 63'd1));
    send_request(request_of(64'd1, 63'd1));
    send_request(request_of(64'd3, 63'd7));
    send_request(request_of(64'd6, 63'd9));
    send_request(request_of(64'd9, 63'd9));
    send_request(request_of(64'd1, 63'h7FFF_FFFF_FFFF_FFFF));
    send_request(request_of(64'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF));
    send_request(request_of(64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF));
    send_request(request_of(64'hFFFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF));
    send_request(request_of(64'h8000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF));
    send_request(request_of(64'hFFFF_FFFF_FFFF_FFFF, 63'h1FFF_FFFF_FFFF_FFFF));
    // consecutive fibonacci numbers, longest euclid chain
    send_request(request_of(64'd4660046610375530309, 63'd7540113804746346429));
    send_request(request_of(64'd12200160415121876738, 63'd7540113804746346429));
    send_request(request_of(64'd2, 63'h4000_0000_0000_0000));
    send_request(request_of(64'd12345, 63'd1000000007));
    send_request(request_of(64'd1000012352, 63'd1000000007));
    send_request(request_of(64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAB));

    // random phases with different idling
    run_phase(105, 0, 0);
    run_phase(105, 70, 0);
    run_phase(105, 0, 70);
    run_phase(105, 33, 33);

    // long hold-off on results while requests keep coming
    send_idle_pct = 0;
    stall_pct     = 0;
    fork
      hold_off(HoldCycles);
      send_random(80);
    join

    @(negedge clk) req_valid <= 1'b0;
    while (inverse_sb.pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (inverse_sb.errors == 0)
      $display("** modular_inverse_ext_euclid: PASSED **");
    else
      $display("** modular_inverse_ext_euclid: FAILED **");
    $finish;
  end

endmodule
